// ===== src/uartrb_pkg.sv =====
// ----------------------------------------------------------------------------
// uartrb_pkg
// Operation and status codes shared by the uart ring buffer block.
// ----------------------------------------------------------------------------
package uartrb_pkg;

  typedef enum logic [2:0] {
    OpHostWrite = 3'd0,
    OpHostRead  = 3'd1,
    OpHostPeek  = 3'd2,
    OpRxByte    = 3'd3,
    OpTxReady   = 3'd4,
    OpRxClear   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRxEmpty  = 2'd1,
    StTxFull   = 2'd2,
    StRxDropped = 2'd3
  } status_e;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned RxLevelW = 6;
  localparam int unsigned TxLevelW = 7;

endpackage

// ===== src/uartrb_ram.sv =====
// ----------------------------------------------------------------------------
// uartrb_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module uartrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/uart_rx_tx_ring_buffers.sv =====
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit ring buffers between a host and a uart.
// ----------------------------------------------------------------------------
// A word is issued by raising start_i with operation_i, data_i, rx_error_i
// and shifter_empty_i; it is taken at the edge where start_i is high and
// busy_o is low. busy_o stays low: a new word can be issued every cycle.
// Exactly one result follows each word, in the cycle after it is taken, and is
// shown for a single cycle with done_o high. The result carries the status,
// the byte read or peeked, the byte handed to the transmit data register,
// both fill levels and the sticky overflow flag.
// The result is registered, as is the read of the two ring rams;
// pointers and counts update at the edge that takes the word, so the next
// word already sees the new state and throughput is one word per cycle.
// Reset clears pointers, counts and the overflow flag; ram contents stay
// undefined and are only read below the fill count.
// The receiver cannot stall: a result not taken in its cycle is gone.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          operation_i,
  input  logic [uartrb_pkg::ByteW-1:0]        data_i,
  input  logic                                rx_error_i,
  input  logic                                shifter_empty_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [uartrb_pkg::ByteW-1:0]        read_data_o,
  output logic                                send_valid_o,
  output logic [uartrb_pkg::ByteW-1:0]        send_data_o,
  output logic [uartrb_pkg::RxLevelW-1:0]     rx_level_o,
  output logic [uartrb_pkg::TxLevelW-1:0]     tx_level_o,
  output logic                                overflow_seen_o
);

  localparam int unsigned RxPtrW = $clog2(RX_DEPTH);
  localparam int unsigned TxPtrW = $clog2(TX_DEPTH);
  localparam int unsigned RxCntW = $clog2(RX_DEPTH);
  localparam int unsigned TxCntW = $clog2(TX_DEPTH + 1);

  logic              accept;
  logic [RxPtrW-1:0] rx_wr_ptr_q, rx_wr_ptr_d, rx_wr_ptr_inc;
  logic [RxPtrW-1:0] rx_rd_ptr_q, rx_rd_ptr_d, rx_rd_ptr_inc;
  logic [RxCntW-1:0] rx_cnt_q, rx_cnt_d;
  logic              ovf_q, ovf_d;
  logic [TxPtrW-1:0] tx_wr_ptr_q, tx_wr_ptr_d, tx_wr_ptr_inc;
  logic [TxPtrW-1:0] tx_rd_ptr_q, tx_rd_ptr_d, tx_rd_ptr_inc;
  logic [TxCntW-1:0] tx_cnt_q, tx_cnt_d;

  logic                         rx_we, tx_we;
  logic [uartrb_pkg::ByteW-1:0] rx_rdata, tx_rdata;

  logic                         done_q;
  uartrb_pkg::status_e          status_q, status_d;
  logic                         rd_sel_q, rd_sel_d;
  logic                         tx_sel_q, tx_sel_d;
  logic                         send_valid_q, send_valid_d;
  logic [uartrb_pkg::ByteW-1:0] send_byte_q, send_byte_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // wrap for depths that are not a power of two
  assign rx_wr_ptr_inc = (rx_wr_ptr_q == RxPtrW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_q + 1'b1;
  assign rx_rd_ptr_inc = (rx_rd_ptr_q == RxPtrW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_q + 1'b1;
  assign tx_wr_ptr_inc = (tx_wr_ptr_q == TxPtrW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_q + 1'b1;
  assign tx_rd_ptr_inc = (tx_rd_ptr_q == TxPtrW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_q + 1'b1;

  always_comb begin
    rx_wr_ptr_d  = rx_wr_ptr_q;
    rx_rd_ptr_d  = rx_rd_ptr_q;
    rx_cnt_d     = rx_cnt_q;
    ovf_d        = ovf_q;
    tx_wr_ptr_d  = tx_wr_ptr_q;
    tx_rd_ptr_d  = tx_rd_ptr_q;
    tx_cnt_d     = tx_cnt_q;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    status_d     = uartrb_pkg::StOk;
    rd_sel_d     = 1'b0;
    tx_sel_d     = 1'b0;
    send_valid_d = 1'b0;
    send_byte_d  = '0;
    if (accept) begin
      unique case (operation_i)
        uartrb_pkg::OpHostWrite: begin
          if ((tx_cnt_q == '0) && shifter_empty_i) begin
            send_valid_d = 1'b1;
            send_byte_d  = data_i;
          end else if (tx_cnt_q == TxCntW'(TX_DEPTH)) begin
            status_d = uartrb_pkg::StTxFull;
          end else begin
            tx_we       = 1'b1;
            tx_wr_ptr_d = tx_wr_ptr_inc;
            tx_cnt_d    = tx_cnt_q + 1'b1;
          end
        end
        uartrb_pkg::OpHostRead, uartrb_pkg::OpHostPeek: begin
          if (rx_cnt_q == '0) begin
            status_d = uartrb_pkg::StRxEmpty;
          end else begin
            rd_sel_d = 1'b1;
            if (operation_i == uartrb_pkg::OpHostRead) begin
              rx_rd_ptr_d = rx_rd_ptr_inc;
              rx_cnt_d    = rx_cnt_q - 1'b1;
            end
          end
        end
        uartrb_pkg::OpRxByte: begin
          if (rx_error_i) begin
            status_d = uartrb_pkg::StRxDropped;
          end else begin
            rx_we       = 1'b1;
            rx_wr_ptr_d = rx_wr_ptr_inc;
            // reaching full depth drops the whole ring
            if (rx_cnt_q == RxCntW'(RX_DEPTH - 1)) begin
              rx_cnt_d    = '0;
              rx_rd_ptr_d = rx_wr_ptr_inc;
              ovf_d       = 1'b1;
            end else begin
              rx_cnt_d = rx_cnt_q + 1'b1;
            end
          end
        end
        uartrb_pkg::OpTxReady: begin
          if (tx_cnt_q != '0) begin
            send_valid_d = 1'b1;
            tx_sel_d     = 1'b1;
            tx_rd_ptr_d  = tx_rd_ptr_inc;
            tx_cnt_d     = tx_cnt_q - 1'b1;
          end
        end
        uartrb_pkg::OpRxClear: begin
          rx_cnt_d    = '0;
          rx_rd_ptr_d = rx_wr_ptr_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_ptr_q <= '0;
      rx_rd_ptr_q <= '0;
      rx_cnt_q    <= '0;
      ovf_q       <= 1'b0;
      tx_wr_ptr_q <= '0;
      tx_rd_ptr_q <= '0;
      tx_cnt_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      rx_wr_ptr_q <= rx_wr_ptr_d;
      rx_rd_ptr_q <= rx_rd_ptr_d;
      rx_cnt_q    <= rx_cnt_d;
      ovf_q       <= ovf_d;
      tx_wr_ptr_q <= tx_wr_ptr_d;
      tx_rd_ptr_q <= tx_rd_ptr_d;
      tx_cnt_q    <= tx_cnt_d;
      done_q      <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    rd_sel_q     <= rd_sel_d;
    tx_sel_q     <= tx_sel_d;
    send_valid_q <= send_valid_d;
    send_byte_q  <= send_byte_d;
  end

  // read port follows the read pointer, so data for the taken word lands
  // in the ram output register at the same edge
  uartrb_ram #(
    .Width (uartrb_pkg::ByteW),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_ptr_q),
    .wdata_i (data_i),
    .raddr_i (rx_rd_ptr_q),
    .rdata_o (rx_rdata)
  );

  uartrb_ram #(
    .Width (uartrb_pkg::ByteW),
    .Depth (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_ptr_q),
    .wdata_i (data_i),
    .raddr_i (tx_rd_ptr_q),
    .rdata_o (tx_rdata)
  );

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_data_o     = rd_sel_q ? rx_rdata : '0;
  assign send_valid_o    = send_valid_q;
  assign send_data_o     = tx_sel_q ? tx_rdata : send_byte_q;
  assign rx_level_o      = uartrb_pkg::RxLevelW'(rx_cnt_q);
  assign tx_level_o      = uartrb_pkg::TxLevelW'(tx_cnt_q);
  assign overflow_seen_o = ovf_q;

endmodule

// ===== verif/uart_rx_tx_ring_buffers_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_tb
// Checks the receive and transmit ring buffers against an in-bench predictor.
// A directed opening covers empty reads, direct and queued host writes,
// dropped receive bytes, clear and the unused operation codes. A random part
// then runs fill and drain phases that drive both rings to full, overflow
// and back, with noise phases in between. Every word taken by the block is
// predicted, and every done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_tb;

  localparam int unsigned RxDepth     = 64;
  localparam int unsigned TxDepth     = 64;
  localparam int unsigned RandomWords = 1030;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  localparam int unsigned ByteW    = uartrb_pkg::ByteW;
  localparam int unsigned RxLevelW = uartrb_pkg::RxLevelW;
  localparam int unsigned TxLevelW = uartrb_pkg::TxLevelW;

  // codes the block ignores
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  typedef enum int unsigned {
    PhRxFill,
    PhRxDrain,
    PhTxFill,
    PhTxDrain,
    PhNoise
  } phase_e;

  typedef struct {
    uartrb_pkg::status_e   status;
    logic [ByteW-1:0]      read_data;
    logic                  send_valid;
    logic [ByteW-1:0]      send_data;
    logic [RxLevelW-1:0]   rx_level;
    logic [TxLevelW-1:0]   tx_level;
    logic                  overflow_seen;
  } ring_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [2:0]          operation_i;
  logic [ByteW-1:0]    data_i;
  logic                rx_error_i;
  logic                shifter_empty_i;
  logic                done_o;
  logic [1:0]          status_o;
  logic [ByteW-1:0]    read_data_o;
  logic                send_valid_o;
  logic [ByteW-1:0]    send_data_o;
  logic [RxLevelW-1:0] rx_level_o;
  logic [TxLevelW-1:0] tx_level_o;
  logic                overflow_seen_o;

  uart_rx_tx_ring_buffers #(
    .RX_DEPTH(RxDepth),
    .TX_DEPTH(TxDepth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .data_i          (data_i),
    .rx_error_i      (rx_error_i),
    .shifter_empty_i (shifter_empty_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .send_valid_o    (send_valid_o),
    .send_data_o     (send_data_o),
    .rx_level_o      (rx_level_o),
    .tx_level_o      (tx_level_o),
    .overflow_seen_o (overflow_seen_o)
  );

  class ring_scoreboard;
    logic [ByteW-1:0] rx_mem [RxDepth];
    logic [ByteW-1:0] tx_mem [TxDepth];
    int unsigned      rx_wr, rx_rd, rx_cnt;
    int unsigned      tx_wr, tx_rd, tx_cnt;
    bit               rx_ovf;
    ring_result_t     expected_q[$];
    int unsigned      fail_count;

    function new();
      rx_wr = 0; rx_rd = 0; rx_cnt = 0; rx_ovf = 0;
      tx_wr = 0; tx_rd = 0; tx_cnt = 0;
      fail_count = 0;
    endfunction

    // predict the result of one accepted word and queue it
    function void note_word(logic [2:0] op, logic [ByteW-1:0] data, logic err, logic se);
      ring_result_t r;
      r.status     = uartrb_pkg::StOk;
      r.read_data  = '0;
      r.send_valid = 1'b0;
      r.send_data  = '0;
      case (op)
        uartrb_pkg::OpHostWrite: begin
          if (tx_cnt == 0 && se) begin
            r.send_valid = 1'b1;
            r.send_data  = data;
          end else if (tx_cnt >= TxDepth) begin
            r.status = uartrb_pkg::StTxFull;
          end else begin
            tx_mem[tx_wr] = data;
            tx_wr = (tx_wr + 1 >= TxDepth) ? 0 : tx_wr + 1;
            tx_cnt++;
          end
        end
        uartrb_pkg::OpHostRead, uartrb_pkg::OpHostPeek: begin
          if (rx_cnt == 0) begin
            r.status = uartrb_pkg::StRxEmpty;
          end else begin
            r.read_data = rx_mem[rx_rd];
            if (op == uartrb_pkg::OpHostRead) begin
              rx_rd = (rx_rd + 1 >= RxDepth) ? 0 : rx_rd + 1;
              rx_cnt--;
            end
          end
        end
        uartrb_pkg::OpRxByte: begin
          if (err) begin
            r.status = uartrb_pkg::StRxDropped;
          end else begin
            rx_mem[rx_wr] = data;
            rx_wr = (rx_wr + 1 >= RxDepth) ? 0 : rx_wr + 1;
            rx_cnt++;
            // a full ring is thrown away and the overflow flag sticks
            if (rx_cnt >= RxDepth) begin
              rx_cnt = 0;
              rx_rd  = rx_wr;
              rx_ovf = 1'b1;
            end
          end
        end
        uartrb_pkg::OpTxReady: begin
          if (tx_cnt != 0) begin
            r.send_valid = 1'b1;
            r.send_data  = tx_mem[tx_rd];
            tx_rd = (tx_rd + 1 >= TxDepth) ? 0 : tx_rd + 1;
            tx_cnt--;
          end
        end
        uartrb_pkg::OpRxClear: begin
          rx_cnt = 0;
          rx_rd  = rx_wr;
        end
        default: begin
        end
      endcase
      r.rx_level      = RxLevelW'(rx_cnt);
      r.tx_level      = TxLevelW'(tx_cnt);
      r.overflow_seen = rx_ovf;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [ByteW-1:0] exp, logic [ByteW-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        fail_count++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result strobe with no word outstanding");
        fail_count++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("status", ByteW'(exp.status), ByteW'(got.status));
      compare_field("read_data", exp.read_data, got.read_data);
      compare_field("send_valid", ByteW'(exp.send_valid), ByteW'(got.send_valid));
      compare_field("send_data", exp.send_data, got.send_data);
      compare_field("rx_level", ByteW'(exp.rx_level), ByteW'(got.rx_level));
      compare_field("tx_level", ByteW'(exp.tx_level), ByteW'(got.tx_level));
      compare_field("overflow_seen", ByteW'(exp.overflow_seen), ByteW'(got.overflow_seen));
    endfunction
  endclass

  ring_scoreboard sb;
  bit             idle_enabled;
  int unsigned    stall_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample on the edge: handshake and result strobe, before any update lands
  always @(posedge clk_i) begin
    ring_result_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.status        = uartrb_pkg::status_e'(status_o);
        got.read_data     = read_data_o;
        got.send_valid    = send_valid_o;
        got.send_data     = send_data_o;
        got.rx_level      = rx_level_o;
        got.tx_level      = tx_level_o;
        got.overflow_seen = overflow_seen_o;
        sb.check_result(got);
      end
      if (start_i && !busy_o) begin
        sb.note_word(operation_i, data_i, rx_error_i, shifter_empty_i);
      end
      if (done_o || (start_i && !busy_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic issue_word(input logic [2:0] op, input logic [ByteW-1:0] data,
                            input logic err, input logic se);
    while (idle_enabled && $urandom_range(0, 99) < 8) begin
      start_i         <= 1'b0;
      operation_i     <= 3'($urandom);
      data_i          <= ByteW'($urandom);
      rx_error_i      <= 1'($urandom);
      shifter_empty_i <= 1'($urandom);
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    operation_i     <= op;
    data_i          <= data;
    rx_error_i      <= err;
    shifter_empty_i <= se;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [2:0] pick_op(phase_e ph);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PhRxFill:  return (roll < 85) ? uartrb_pkg::OpRxByte :
                        (roll < 95) ? uartrb_pkg::OpHostPeek : uartrb_pkg::OpHostRead;
      PhRxDrain: return (roll < 60) ? uartrb_pkg::OpHostRead :
                        (roll < 85) ? uartrb_pkg::OpHostPeek : uartrb_pkg::OpRxByte;
      PhTxFill:  return (roll < 90) ? uartrb_pkg::OpHostWrite : uartrb_pkg::OpTxReady;
      PhTxDrain: return (roll < 75) ? uartrb_pkg::OpTxReady : uartrb_pkg::OpHostWrite;
      default: begin
        if (roll < 4) return OpSpare6;
        if (roll < 8) return OpSpare7;
        if (roll < 14) return uartrb_pkg::OpRxClear;
        return 3'($urandom_range(0, 4));
      end
    endcase
  endfunction

  task automatic run_random();
    phase_e      ph;
    int unsigned sent;
    int unsigned chunk;
    logic [2:0]  op;
    logic        err;
    sent = 0;
    while (sent < RandomWords) begin
      ph    = phase_e'($urandom_range(0, 4));
      chunk = $urandom_range(20, 120);
      for (int unsigned i = 0; i < chunk && sent < RandomWords; i++) begin
        // a long run without idle gaps in the middle of the random part
        idle_enabled = !(sent >= 300 && sent < 560);
        op  = pick_op(ph);
        err = (ph == PhRxFill) ? ($urandom_range(0, 99) < 5) : ($urandom_range(0, 99) < 25);
        issue_word(op, ByteW'($urandom), err, 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb              = new();
    stall_cycles    = 0;
    idle_enabled    = 1'b1;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    operation_i     = uartrb_pkg::OpHostWrite;
    data_i          = '0;
    rx_error_i      = 1'b0;
    shifter_empty_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty rings first
    issue_word(uartrb_pkg::OpHostRead, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpHostPeek, 8'hff, 1'b1, 1'b1);
    issue_word(uartrb_pkg::OpTxReady, 8'h00, 1'b0, 1'b1);
    // direct write, then queued writes behind a busy register
    issue_word(uartrb_pkg::OpHostWrite, 8'h00, 1'b0, 1'b1);
    issue_word(uartrb_pkg::OpHostWrite, 8'hff, 1'b1, 1'b0);
    issue_word(uartrb_pkg::OpHostWrite, 8'ha5, 1'b0, 1'b1);
    issue_word(uartrb_pkg::OpTxReady, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpTxReady, 8'hff, 1'b1, 1'b1);
    issue_word(uartrb_pkg::OpTxReady, 8'h00, 1'b0, 1'b0);
    // receive side: dropped byte, stored bytes, peek and read
    issue_word(uartrb_pkg::OpRxByte, 8'hff, 1'b1, 1'b0);
    issue_word(uartrb_pkg::OpRxByte, 8'h00, 1'b0, 1'b1);
    issue_word(uartrb_pkg::OpRxByte, 8'hff, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpHostPeek, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpHostRead, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpHostRead, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpHostRead, 8'h00, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpRxByte, 8'h5a, 1'b0, 1'b0);
    issue_word(uartrb_pkg::OpRxByte, 8'h3c, 1'b0, 1'b1);
    issue_word(uartrb_pkg::OpRxClear, 8'hff, 1'b1, 1'b1);
    issue_word(uartrb_pkg::OpHostPeek, 8'h00, 1'b0, 1'b0);
    issue_word(OpSpare6, 8'hff, 1'b1, 1'b1);
    issue_word(OpSpare7, 8'h00, 1'b0, 1'b0);

    run_random();

    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
